// ===== design/vna_pkg.sv =====
// Package for the vertex normal averaging block: widths, constants, types.
// No dependencies; used by every module in design/.
package vna_pkg;
	localparam int CoordBits = 20;
	localparam int MaxTriangles = 1024;
	localparam int CntBits = 11;
	localparam int SumBits = 28;
	localparam int OneQ14 = 16384;

	typedef enum logic [1:0] {
		OP_SQRT,
		OP_DIV
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL_A,
		ST_MUL_B,
		ST_CROSS,
		ST_MAG,
		ST_NORM,
		ST_SQ0,
		ST_SQ1,
		ST_SQ2,
		ST_SQRT,
		ST_SQRT_W,
		ST_UDIV,
		ST_UDIV_W,
		ST_UACC,
		ST_ADIV,
		ST_ADIV_W,
		ST_AST,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic  start;
		op_t   op;
		logic [63:0] num;
		logic [31:0] den;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} unit_rsp_t;
endpackage

// ===== design/vertex_normal_average.sv =====
// Top level of the vertex normal averaging block: sequencer, datapath, ports.
// Depends on vna_pkg and vna_unit.
//
// Input: s_axis_* carries one triangle per transaction (tdata: vertex_index,
// a_x..c_z), tuser = has_triangle, tlast = last item of a vertex.
// Output: m_axis_* carries one result per vertex on the last item, tdata:
// out_vertex, normal_x, normal_y, normal_z; tuser = used_default.
// One item at a time: s_axis_tready is high only in idle. A triangle item
// passes through the differences, the cross product on two 21x21
// multipliers and the sum of squares; then the shared unit computes the root
// and each of three divides, and the quotients are accumulated. A degenerate
// triangle skips the root and the divides. A last item adds three more
// divides for the average when the count is not zero, then loads the output
// register. Items without a triangle, or past MaxTriangles, skip the triangle steps and, if not last,
// go back to idle after the differences. The result sits in an output register; a stalled receiver
// holds the block only when the next result is ready while the previous one
// is still waiting. Reset clears sums, count, and sets zero_tolerance to 2.
module vertex_normal_average (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [207:0] s_axis_tdata,  // vertex_index, a_x,a_y,a_z,b_x..b_z,c_x..c_z
	input  logic         s_axis_tuser,  // has_triangle
	input  logic         s_axis_tlast,  // last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata,  // out_vertex, normal_x, normal_y, normal_z
	output logic         m_axis_tuser,  // used_default
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata
);
	localparam int CB = vna_pkg::CoordBits;
	localparam int DB = CB + 1;

	vna_pkg::state_t state_q, state_d;
	vna_pkg::unit_req_t req;
	vna_pkg::unit_rsp_t rsp;

	logic [7:0]  tol_q;
	logic signed [vna_pkg::SumBits-1:0] sum_q [3];
	logic [vna_pkg::CntBits-1:0] cnt_q;
	logic [23:0] vtx_q;
	logic        tri_q, last_q;
	logic signed [CB-1:0] crd_q [9];
	logic signed [DB-1:0] u_q [3];
	logic signed [DB-1:0] v_q [3];
	logic signed [2*DB-1:0] pa_q [3];
	logic signed [2*DB+1:0] n_q [3];
	logic [2*DB:0] m_q [3];
	logic [63:0] lsum_q;
	logic [31:0] r_q;
	logic [1:0]  idx_q;
	logic signed [15:0] avg_q [3];
	logic [71:0] otd_q;
	logic        ousr_q, ovld_q;

	// Shared multiplier inputs.
	logic signed [DB-1:0] mul_a, mul_b;
	logic signed [2*DB-1:0] mul_p;
	logic [2*DB:0] mxv;
	logic [6:0]  bl;
	logic [29:0] msel;
	logic [59:0] sq_p;
	logic [63:0] sm;
	logic [63:0] qnum;
	logic [vna_pkg::SumBits-1:0] smag;
	logic [63:0] q;
	logic        near0;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			vna_pkg::ST_MUL_A: begin mul_a = u_q[1]; mul_b = v_q[2]; end
			vna_pkg::ST_MUL_B: begin mul_a = u_q[2]; mul_b = v_q[0]; end
			vna_pkg::ST_CROSS: begin mul_a = u_q[0]; mul_b = v_q[1]; end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	// Second products come in the same pattern in the following state; a small set of
	// product registers keeps each multiplier at one multiply per cycle.
	logic signed [DB-1:0] mb_a, mb_b;
	logic signed [2*DB-1:0] mb_p;
	always_comb begin
		mb_a = '0;
		mb_b = '0;
		unique case (state_q)
			vna_pkg::ST_MUL_B: begin mb_a = u_q[2]; mb_b = v_q[1]; end
			vna_pkg::ST_CROSS: begin mb_a = u_q[0]; mb_b = v_q[2]; end
			vna_pkg::ST_MAG:   begin mb_a = u_q[1]; mb_b = v_q[0]; end
			default: ;
		endcase
		mb_p = mb_a * mb_b;
	end

	always_comb begin
		mxv = m_q[0];
		if (m_q[1] > mxv) mxv = m_q[1];
		if (m_q[2] > mxv) mxv = m_q[2];
		bl = '0;
		for (int i = 0; i < 2*DB+1; i++)
			if (mxv[i]) bl = 7'(i + 1);
		// After scaling every magnitude is below 2^29, so 30 bits carry each magnitude and 60 bits its square.
		msel = m_q[idx_q][29:0];
		sq_p = msel * msel;
		sm = 64'(sq_p);
		qnum = (64'(m_q[idx_q]) << 14) + 64'(r_q >> 1);
		smag = sum_q[idx_q][vna_pkg::SumBits-1] ? vna_pkg::SumBits'(-sum_q[idx_q])
			: vna_pkg::SumBits'(sum_q[idx_q]);
		q = rsp.res;
		near0 = 1'b1;
		for (int i = 0; i < 3; i++)
			if ((avg_q[i][15] ? 16'(-avg_q[i]) : 16'(avg_q[i])) > 16'(tol_q))
				near0 = 1'b0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vna_pkg::ST_IDLE: if (s_axis_tvalid) state_d = vna_pkg::ST_DIFF;
			vna_pkg::ST_DIFF:
				if (tri_q && cnt_q < vna_pkg::CntBits'(vna_pkg::MaxTriangles))
					state_d = vna_pkg::ST_MUL_A;
				else if (last_q) state_d = (cnt_q == '0) ? vna_pkg::ST_AST
					: vna_pkg::ST_ADIV;
				else state_d = vna_pkg::ST_IDLE;
			vna_pkg::ST_MUL_A: state_d = vna_pkg::ST_MUL_B;
			vna_pkg::ST_MUL_B: state_d = vna_pkg::ST_CROSS;
			vna_pkg::ST_CROSS: state_d = vna_pkg::ST_MAG;
			vna_pkg::ST_MAG:   state_d = vna_pkg::ST_NORM;
			vna_pkg::ST_NORM:  state_d = (mxv == '0) ? vna_pkg::ST_UACC : vna_pkg::ST_SQ0;
			vna_pkg::ST_SQ0:   state_d = vna_pkg::ST_SQ1;
			vna_pkg::ST_SQ1:   state_d = vna_pkg::ST_SQ2;
			vna_pkg::ST_SQ2:   state_d = vna_pkg::ST_SQRT;
			vna_pkg::ST_SQRT:  state_d = vna_pkg::ST_SQRT_W;
			vna_pkg::ST_SQRT_W: if (rsp.done) state_d = vna_pkg::ST_UDIV;
			vna_pkg::ST_UDIV:  state_d = vna_pkg::ST_UDIV_W;
			vna_pkg::ST_UDIV_W:
				if (rsp.done) state_d = (idx_q == 2'd2) ? vna_pkg::ST_UACC : vna_pkg::ST_UDIV;
			vna_pkg::ST_UACC:
				if (last_q) state_d = vna_pkg::ST_ADIV;
				else state_d = vna_pkg::ST_IDLE;
			vna_pkg::ST_ADIV:  state_d = vna_pkg::ST_ADIV_W;
			vna_pkg::ST_ADIV_W:
				if (rsp.done) state_d = (idx_q == 2'd2) ? vna_pkg::ST_AST : vna_pkg::ST_ADIV;
			vna_pkg::ST_AST:   state_d = vna_pkg::ST_OUT;
			vna_pkg::ST_OUT:   if (!ovld_q || m_axis_tready) state_d = vna_pkg::ST_IDLE;
			default: state_d = vna_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.start = 1'b0;
		req.op = vna_pkg::OP_SQRT;
		req.num = lsum_q;
		req.den = r_q;
		unique case (state_q)
			vna_pkg::ST_SQRT: req.start = 1'b1;
			vna_pkg::ST_UDIV: begin
				req.start = 1'b1;
				req.op = vna_pkg::OP_DIV;
				req.num = qnum;
			end
			vna_pkg::ST_ADIV: begin
				req.start = 1'b1;
				req.op = vna_pkg::OP_DIV;
				req.num = 64'(smag) + 64'(cnt_q >> 1);
				req.den = 32'(cnt_q);
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == vna_pkg::ST_IDLE);

	vna_unit u_unit (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vna_pkg::ST_IDLE;
			tol_q   <= 8'd2;
			cnt_q   <= '0;
			ovld_q  <= 1'b0;
			idx_q   <= '0;
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) tol_q <= cfg_wdata;
			if (state_q == vna_pkg::ST_OUT && (!ovld_q || m_axis_tready)) ovld_q <= 1'b1;
			else if (ovld_q && m_axis_tready) ovld_q <= 1'b0;
			unique case (state_q)
				vna_pkg::ST_IDLE: if (s_axis_tvalid) begin
					vtx_q  <= s_axis_tdata[23:0];
					tri_q  <= s_axis_tuser;
					last_q <= s_axis_tlast;
					for (int i = 0; i < 9; i++)
						crd_q[i] <= s_axis_tdata[24 + i*CB +: CB];
				end
				vna_pkg::ST_DIFF: begin
					for (int i = 0; i < 3; i++) begin
						u_q[i] <= DB'(crd_q[i]) - DB'(crd_q[6+i]);
						v_q[i] <= DB'(crd_q[3+i]) - DB'(crd_q[6+i]);
					end
					idx_q <= '0;
				end
				vna_pkg::ST_MUL_A: pa_q[0] <= mul_p;
				vna_pkg::ST_MUL_B: begin
					pa_q[1] <= mul_p;
					n_q[0] <= (2*DB+2)'(pa_q[0]) - (2*DB+2)'(mb_p);
				end
				vna_pkg::ST_CROSS: begin
					pa_q[2] <= mul_p;
					n_q[1] <= (2*DB+2)'(pa_q[1]) - (2*DB+2)'(mb_p);
					cnt_q <= cnt_q + 1'b1;
				end
				vna_pkg::ST_MAG: begin
					n_q[2] <= (2*DB+2)'(pa_q[2]) - (2*DB+2)'(mb_p);
					for (int i = 0; i < 2; i++)
						m_q[i] <= n_q[i][2*DB+1] ? (2*DB+1)'(-n_q[i]) : (2*DB+1)'(n_q[i]);
					m_q[2] <= (pa_q[2] - mb_p) < 0 ? (2*DB+1)'(-((2*DB+2)'(pa_q[2]) -
						(2*DB+2)'(mb_p))) : (2*DB+1)'((2*DB+2)'(pa_q[2]) - (2*DB+2)'(mb_p));
				end
				vna_pkg::ST_NORM: begin
					for (int i = 0; i < 3; i++)
						m_q[i] <= (bl > 7'd29) ? m_q[i] >> (bl - 7'd29)
							: (2*DB+1)'(m_q[i] << (7'd29 - bl));
					lsum_q <= '0;
				end
				vna_pkg::ST_SQ0, vna_pkg::ST_SQ1, vna_pkg::ST_SQ2: begin
					lsum_q <= lsum_q + sm;
					idx_q  <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
				vna_pkg::ST_SQRT_W: if (rsp.done) r_q <= rsp.res[31:0];
				vna_pkg::ST_UDIV_W: if (rsp.done) begin
					sum_q[idx_q] <= sum_q[idx_q] + (n_q[idx_q][2*DB+1]
						? -vna_pkg::SumBits'(q) : vna_pkg::SumBits'(q));
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
				vna_pkg::ST_UACC: idx_q <= '0;
				vna_pkg::ST_ADIV_W: if (rsp.done) begin
					avg_q[idx_q] <= sum_q[idx_q][vna_pkg::SumBits-1] ? -16'(q) : 16'(q);
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
				vna_pkg::ST_AST: if (cnt_q == '0) begin
					for (int i = 0; i < 3; i++) avg_q[i] <= '0;
				end
				vna_pkg::ST_OUT: if (!ovld_q || m_axis_tready) begin
					ousr_q <= near0;
					otd_q  <= near0 ? {16'(vna_pkg::OneQ14), 32'd0, vtx_q}
						: {avg_q[2], avg_q[1], avg_q[0], vtx_q};
					cnt_q  <= '0;
					for (int i = 0; i < 3; i++) sum_q[i] <= '0;
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = otd_q;
	assign m_axis_tuser  = ousr_q;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= vna_pkg::CntBits'(vna_pkg::MaxTriangles)) else $error("count overflow");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == vna_pkg::ST_IDLE) else $error("ready outside idle");
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> cnt_q == '0) else $error("state not cleared");
endmodule

// ===== design/vna_unit.sv =====
// Shared iterative unit: 64-bit integer square root or 64/32 division,
// one result bit per cycle. Depends on vna_pkg.
module vna_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  vna_pkg::unit_req_t req,
	output vna_pkg::unit_rsp_t rsp
);
	logic        busy_q;
	vna_pkg::op_t op_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] num_q;
	logic [31:0] den_q;
	logic        done_q;

	logic [65:0] trial;
	logic [64:0] drem;
	logic [63:0] sbit;

	always_comb begin
		// Digit-by-digit root: bit = 4^cnt; remainder compares against res + bit.
		sbit = 64'd1 << {cnt_q, 1'b0};
		trial = {2'b0, rem_q} - {2'b0, res_q} - {2'b0, sbit};
		drem = {rem_q, num_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= vna_pkg::OP_SQRT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == vna_pkg::OP_SQRT) ? 6'd31 : 6'd63;
				rem_q  <= (req.op == vna_pkg::OP_SQRT) ? req.num : 64'd0;
				num_q  <= req.num;
				den_q  <= req.den;
				res_q  <= '0;
			end else if (busy_q) begin
				if (op_q == vna_pkg::OP_SQRT) begin
					if (!trial[65]) begin
						rem_q <= trial[63:0];
						res_q <= (res_q >> 1) + sbit;
					end else begin
						res_q <= res_q >> 1;
					end
				end else begin
					num_q <= {num_q[62:0], 1'b0};
					if (drem >= {33'd0, den_q}) begin
						rem_q <= 64'(drem - {33'd0, den_q});
						res_q <= {res_q[62:0], 1'b1};
					end else begin
						rem_q <= drem[63:0];
						res_q <= {res_q[62:0], 1'b0};
					end
				end
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q)) else $error("done without work");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start) else $error("start while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("done held");
endmodule
